[rtl/core/calclk_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package calclk_pkg;

    // operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_HOUR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_MINUTE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_SECOND = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_EN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_SET    = 3'd4;
    localparam int CFG_DATA_W = 6;

    // text characters
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [63:0] ALARM_DASHES = 64'h2D2D_3A2D_2D3A_2D2D;

    typedef struct packed {
        logic       op;
        logic [5:0] set_second;
        logic [5:0] set_minute;
        logic [4:0] set_hour;
        logic [5:0] set_day;
        logic [3:0] set_month;
        logic [6:0] set_year;
    } calclk_in_t;

    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hours;
        logic [5:0]  day_of_month;
        logic [3:0]  month_number;
        logic [6:0]  year_number;
        logic [63:0] time_text;
        logic [63:0] date_text;
        logic [63:0] alarm_text;
    } calclk_out_t;

    // two ascii digits of (v/10)%10 and v%10, via reciprocal multiply
    function automatic logic [15:0] two_digits(input logic [6:0] v);
        logic [17:0] prod;
        logic [3:0]  quo;
        logic [3:0]  tens;
        logic [6:0]  ones;
        prod = 18'(v) * 18'd205;
        quo  = prod[14:11];
        tens = (quo >= 4'd10) ? quo - 4'd10 : quo;
        ones = v - 7'(quo) * 7'd10;
        return {CHAR_ZERO + 8'(tens), CHAR_ZERO + 8'(ones)};
    endfunction

    // "aa<sep>bb<sep>cc", first character in the top byte
    function automatic logic [63:0] pack_text(input logic [6:0] a, input logic [6:0] b,
                                              input logic [6:0] c, input logic [7:0] sep);
        return {two_digits(a), sep, two_digits(b), sep, two_digits(c)};
    endfunction

endpackage

`default_nettype wire

[rtl/core/calendar_clock_with_text.sv]
`timescale 1ns / 1ps
`default_nettype none

// Calendar clock with hh:mm:ss, dd.mm.yy and alarm text. One input beat
// (tick or load) is taken every clock cycle while s_ready is high. The
// counters update at the accepting edge; the text stage then loads the
// result beat into m_data once m_data is free, which raises m_valid.
// While a result waits for m_ready, the counter stage can take one more
// beat; after that s_ready stays low until the waiting result is taken.
// The user must write alarm registers through the cfg port only while
// the block is idle (not enforced by it); the text stage reads them.
module calendar_clock_with_text
    import calclk_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output      logic                  s_ready,
    input  wire calclk_in_t            s_data,
    output      logic                  m_valid,
    input  wire logic                  m_ready,
    output      calclk_out_t           m_data,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data
);

    // counter state
    logic [5:0] sec_reg, sec_next;
    logic [5:0] min_reg, min_next;
    logic [4:0] hour_reg, hour_next;
    logic [5:0] day_reg, day_next;
    logic [3:0] mon_reg, mon_next;
    logic [6:0] year_reg, year_next;
    logic       upd_vld_reg;

    // alarm registers
    logic [4:0] al_hour_reg;
    logic [5:0] al_min_reg;
    logic [5:0] al_sec_reg;
    logic       al_en_reg;
    logic       al_set_reg;

    // output stage
    logic        m_valid_reg;
    calclk_out_t m_data_reg, m_data_next;

    logic s_fire;
    logic out_load;

    assign out_load = upd_vld_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !upd_vld_reg || out_load;
    assign s_fire   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // tick cascade and load checks
    logic [6:0] t_sec1;
    logic       t_sec_wrap;
    logic [6:0] t_min1;
    logic       t_min_wrap;
    logic [5:0] t_hour1;
    logic       t_hour_wrap;
    logic [5:0] t_day1;
    logic [5:0] t_day;
    logic [3:0] t_mon;
    logic [7:0] t_year;
    logic       leap;
    logic       long_m;
    logic       short_m;
    logic [3:0] l_mon;
    logic [5:0] l_day;
    logic       l_leap;
    logic       l_long;
    logic       l_short;

    always_comb begin
        // tick path
        t_sec1      = 7'(sec_reg) + 7'd1;
        t_sec_wrap  = t_sec1 >= 7'd60;
        t_min1      = 7'(min_reg) + 7'(t_sec_wrap);
        t_min_wrap  = t_min1 >= 7'd60;
        t_hour1     = 6'(hour_reg) + 6'(t_min_wrap);
        t_hour_wrap = t_hour1 >= 6'd24;
        t_day1      = (t_hour_wrap && day_reg < 6'd63) ? day_reg + 6'd1 : day_reg;
        t_day       = t_day1;
        t_mon       = mon_reg;
        t_year      = 8'(year_reg);
        leap        = year_reg[1:0] == 2'd0;
        long_m      = mon_reg == 4'd1 || mon_reg == 4'd3 || mon_reg == 4'd5 ||
                      mon_reg == 4'd7 || mon_reg == 4'd8 || mon_reg == 4'd10;
        short_m     = mon_reg == 4'd4 || mon_reg == 4'd6 || mon_reg == 4'd9 ||
                      mon_reg == 4'd11;
        if (mon_reg == 4'd2) begin
            if ((leap && t_day1 == 6'd30) || (!leap && t_day1 == 6'd29)) begin
                t_mon = mon_reg + 4'd1;
                t_day = 6'd1;
            end
        end else if (long_m) begin
            if (t_day1 >= 6'd32) begin
                t_mon = mon_reg + 4'd1;
                t_day = 6'd1;
            end
        end else if (short_m) begin
            if (t_day1 >= 6'd31) begin
                t_mon = mon_reg + 4'd1;
                t_day = 6'd1;
            end
        end else if (mon_reg >= 4'd12) begin
            if (t_day1 >= 6'd32) begin
                t_mon  = 4'd1;
                t_day  = 6'd1;
                t_year = 8'(year_reg) + 8'd1;
            end
        end
        if (t_year >= 8'd100) begin
            t_year = 8'd0;
        end

        // load path
        l_mon   = (s_data.set_month >= 4'd13) ? 4'd0 : s_data.set_month;
        l_leap  = s_data.set_year[1:0] == 2'd0;
        l_long  = l_mon == 4'd1 || l_mon == 4'd3 || l_mon == 4'd5 || l_mon == 4'd7 ||
                  l_mon == 4'd8 || l_mon == 4'd10 || l_mon == 4'd12;
        l_short = l_mon == 4'd4 || l_mon == 4'd6 || l_mon == 4'd9 || l_mon == 4'd11;
        l_day   = s_data.set_day;
        if (l_mon == 4'd2 && l_leap && s_data.set_day == 6'd30) begin
            l_day = 6'd0;
        end
        if (l_mon == 4'd2 && !l_leap && s_data.set_day == 6'd29) begin
            l_day = 6'd0;
        end
        if (l_long && s_data.set_day == 6'd32) begin
            l_day = 6'd0;
        end
        if (l_short && s_data.set_day == 6'd31) begin
            l_day = 6'd0;
        end

        // select
        if (s_data.op == OP_LOAD) begin
            sec_next  = (s_data.set_second >= 6'd60) ? 6'd0 : s_data.set_second;
            min_next  = (s_data.set_minute >= 6'd60) ? 6'd0 : s_data.set_minute;
            hour_next = (s_data.set_hour >= 5'd24) ? 5'd0 : s_data.set_hour;
            day_next  = l_day;
            mon_next  = l_mon;
            year_next = (s_data.set_year >= 7'd100) ? 7'd0 : s_data.set_year;
        end else begin
            sec_next  = t_sec_wrap ? 6'd0 : t_sec1[5:0];
            min_next  = t_min_wrap ? 6'd0 : t_min1[5:0];
            hour_next = t_hour_wrap ? 5'd0 : t_hour1[4:0];
            day_next  = t_day;
            mon_next  = t_mon;
            year_next = t_year[6:0];
        end
    end

    // counter stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sec_reg     <= 6'd0;
            min_reg     <= 6'd0;
            hour_reg    <= 5'd0;
            day_reg     <= 6'd1;
            mon_reg     <= 4'd1;
            year_reg    <= 7'd0;
            upd_vld_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                sec_reg  <= sec_next;
                min_reg  <= min_next;
                hour_reg <= hour_next;
                day_reg  <= day_next;
                mon_reg  <= mon_next;
                year_reg <= year_next;
            end
            if (s_fire) begin
                upd_vld_reg <= 1'b1;
            end else if (out_load) begin
                upd_vld_reg <= 1'b0;
            end
        end
    end

    // alarm register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            al_hour_reg <= 5'd0;
            al_min_reg  <= 6'd0;
            al_sec_reg  <= 6'd0;
            al_en_reg   <= 1'b0;
            al_set_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_ALARM_HOUR:   al_hour_reg <= cfg_wr_data[4:0];
                CFG_ALARM_MINUTE: al_min_reg  <= cfg_wr_data;
                CFG_ALARM_SECOND: al_sec_reg  <= cfg_wr_data;
                CFG_ALARM_EN:     al_en_reg   <= cfg_wr_data[0];
                CFG_ALARM_SET:    al_set_reg  <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // text stage
    logic [6:0] al_h;
    logic [6:0] al_m;
    logic [6:0] al_s;

    always_comb begin
        al_h = (al_hour_reg >= 5'd24) ? 7'd0 : 7'(al_hour_reg);
        al_m = (al_min_reg >= 6'd60) ? 7'd0 : 7'(al_min_reg);
        al_s = (al_sec_reg >= 6'd60) ? 7'd0 : 7'(al_sec_reg);
        m_data_next.second       = sec_reg;
        m_data_next.minute       = min_reg;
        m_data_next.hours        = hour_reg;
        m_data_next.day_of_month = day_reg;
        m_data_next.month_number = mon_reg;
        m_data_next.year_number  = year_reg;
        m_data_next.time_text    = pack_text(7'(hour_reg), 7'(min_reg), 7'(sec_reg),
                                             CHAR_COLON);
        m_data_next.date_text    = pack_text(7'(day_reg), 7'(mon_reg), year_reg, CHAR_DOT);
        if (!al_en_reg && !al_set_reg) begin
            m_data_next.alarm_text = ALARM_DASHES;
        end else begin
            m_data_next.alarm_text = pack_text(al_h, al_m, al_s, CHAR_COLON);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/calclk_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module calclk_checker
    import calclk_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_ready,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire calclk_out_t           m_data
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // reset empties the pipe
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("pipe not empty after reset");

    // time fields stay in range
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.second < 6'd60 && m_data.minute < 6'd60 &&
                    m_data.hours < 5'd24 && m_data.year_number < 7'd100)
        else $error("time field out of range");

    // one time and one date separator and the last time digit character
    a_text: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.time_text[47:40] == CHAR_COLON &&
                    m_data.date_text[23:16] == CHAR_DOT &&
                    m_data.time_text[7:0] >= CHAR_ZERO && m_data.time_text[7:0] <= 8'h39)
        else $error("malformed text");

endmodule

bind calendar_clock_with_text calclk_checker u_calclk_checker (.*);

`default_nettype wire
